### hw/rtl/rrrp_pkg.sv
// shared constants, types and codes for the round robin replica placement block
`timescale 1ns / 1ps
`default_nettype none

package rrrp_pkg;

  // capacity
  localparam int MAX_NODES    = 64;
  localparam int MAX_REPLICAS = 8;

  // derived widths
  localparam int NODE_IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int REP_N_W    = $clog2(MAX_REPLICAS + 1);
  localparam int MEM_AW     = NODE_IDX_W + 1;
  localparam int SH_W       = NODE_IDX_W + 1;
  localparam int MOD_STEP_W = $clog2(NODE_IDX_W + 1);

  // fixed field widths
  localparam int NODE_ID_W   = 16;
  localparam int SPACE_W     = 48;
  localparam int BLOCK_ID_W  = 48;
  localparam int BSIZE_W     = 32;
  localparam int REPL_W      = 4;
  localparam int CMP_W       = (CNT_W > REPL_W) ? CNT_W : REPL_W;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLICATION = 1'b1;

  // reset values
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST  = 32'd67108864;
  localparam logic [REPL_W-1:0]  REPLICATION_RST = 4'd3;

  // one finished list handed from front to back
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] kept;
  } job_t;

  // id store write request from the front
  typedef struct packed {
    logic                 en;
    logic [MEM_AW-1:0]    addr;
    logic [NODE_ID_W-1:0] data;
  } mem_wr_t;

  // back releases a bank when its list is placed
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_done_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MOD,
    BK_LOAD,
    BK_NONE
  } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/rrrp_job_fifo.sv
// two-entry job queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module rrrp_job_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rrrp_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               job_valid,
  output rrrp_pkg::job_t     job
);
  import rrrp_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       full;

  assign full      = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> job_valid)
    else $error("job queue read while empty");

endmodule

`default_nettype wire

### hw/rtl/rrrp_front.sv
// front: takes node entries, filters eligible ones into a bank, closes a list on last
`timescale 1ns / 1ps
`default_nettype none

module rrrp_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rrrp_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                               in_tlast,
  input  wire logic [rrrp_pkg::BSIZE_W-1:0]       block_size,
  input  wire rrrp_pkg::bank_done_t               done,
  output rrrp_pkg::mem_wr_t                       wr,
  output logic                                    job_push,
  output rrrp_pkg::job_t                          job
);
  import rrrp_pkg::*;

  logic                 bank_r, bank_nxt;
  logic [1:0]           busy_r, busy_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 accept;
  logic                 eligible;
  logic [NODE_ID_W-1:0] node_id;
  logic                 node_alive;
  logic [SPACE_W-1:0]   node_space;

  // unpack the entry
  assign node_id    = in_tdata[NODE_ID_W-1:0];
  assign node_alive = in_tdata[NODE_ID_W];
  assign node_space = in_tdata[NODE_ID_W+SPACE_W:NODE_ID_W+1];

  // a bank is open for filling only once the back has released it
  assign in_tready = !busy_r[bank_r];
  assign accept    = in_tvalid && in_tready;

  // alive, enough space, and room left in the bank
  assign eligible = node_alive
                 && (node_space >= {{(SPACE_W-BSIZE_W){1'b0}}, block_size})
                 && (cnt_r < CNT_W'(MAX_NODES));

  assign wr.en   = accept && eligible;
  assign wr.addr = {bank_r, cnt_r[NODE_IDX_W-1:0]};
  assign wr.data = node_id;

  assign job_push = accept && in_tlast;
  assign job.bank = bank_r;
  assign job.kept = cnt_r + CNT_W'(wr.en);

  // fill count, bank select and bank busy flags
  always_comb begin
    cnt_nxt  = cnt_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    if (done.valid) begin
      busy_nxt[done.bank] = 1'b0;
    end
    if (accept) begin
      if (in_tlast) begin
        cnt_nxt          = '0;
        bank_nxt         = ~bank_r;
        busy_nxt[bank_r] = 1'b1;
      end else if (wr.en) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bank_r <= 1'b0;
      busy_r <= 2'b00;
    end else begin
      cnt_r  <= cnt_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

  a_release_busy_only: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> busy_r[done.bank])
    else $error("back released a bank that was not handed over");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NODES))
    else $error("bank fill count beyond capacity");

endmodule

`default_nettype wire

### hw/rtl/rrrp_back.sv
// back: id store, pointer remainder, round robin selection and result register
`timescale 1ns / 1ps
`default_nettype none

module rrrp_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire rrrp_pkg::mem_wr_t                  wr,
  input  wire logic                               job_valid,
  input  wire rrrp_pkg::job_t                     job,
  output logic                                    job_pop,
  input  wire logic [rrrp_pkg::REPL_W-1:0]        replication,
  output rrrp_pkg::bank_done_t                    done,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rrrp_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tuser,
  output logic                                    out_tlast
);
  import rrrp_pkg::*;

  // id store, two banks of MAX_NODES
  logic [NODE_ID_W-1:0] mem [2*MAX_NODES];
  logic [NODE_ID_W-1:0] rd_data_r;
  logic                 rd_en;
  logic [MEM_AW-1:0]    rd_addr;

  back_state_t          state_r, state_nxt;
  logic                 bank_r, bank_nxt;
  logic [CNT_W-1:0]     kept_r, kept_nxt;
  logic [REP_N_W-1:0]   n_r, n_nxt;
  logic [REP_N_W-1:0]   i_r, i_nxt;
  logic [NODE_IDX_W-1:0] idx_r, idx_nxt;
  logic [NODE_IDX_W-1:0] rem_r, rem_nxt;
  logic [MOD_STEP_W-1:0] step_r, step_nxt;
  logic [NODE_IDX_W-1:0] ptr_r, ptr_nxt;
  logic [BLOCK_ID_W-1:0] blk_r, blk_nxt;

  logic                  ov_r, ov_nxt;
  logic [BLOCK_ID_W-1:0] o_blk_r, o_blk_nxt;
  logic [NODE_ID_W-1:0]  o_node_r, o_node_nxt;
  logic                  o_none_r, o_none_nxt;
  logic                  o_last_r, o_last_nxt;

  logic                  out_free;
  logic [SH_W-1:0]       rem_sh;
  logic [SH_W-1:0]       rem_step;
  logic [REPL_W-1:0]     want;
  logic [CMP_W-1:0]      want_c, kept_c;
  logic [NODE_IDX_W-1:0] idx_inc;
  logic                  is_last_pick;

  assign out_free = !ov_r || out_tready;

  // replication clamped to one..MAX_REPLICAS
  always_comb begin
    if (replication == '0) begin
      want = REPL_W'(1);
    end else if ({1'b0, replication} > (REPL_W+1)'(MAX_REPLICAS)) begin
      want = REPL_W'(MAX_REPLICAS);
    end else begin
      want = replication;
    end
  end
  assign want_c = CMP_W'(want);
  assign kept_c = CMP_W'(job.kept);

  // one restoring remainder step of pointer mod kept
  assign rem_sh   = {rem_r, ptr_r[step_r]};
  assign rem_step = (rem_sh >= SH_W'(kept_r)) ? (rem_sh - SH_W'(kept_r)) : rem_sh;

  // next list position, wrapping at kept
  assign idx_inc = ({1'b0, idx_r} + SH_W'(1) == SH_W'(kept_r)) ? '0 : idx_r + NODE_IDX_W'(1);
  assign is_last_pick = (i_r + REP_N_W'(1) == n_r);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    kept_nxt   = kept_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    ptr_nxt    = ptr_r;
    blk_nxt    = blk_r;
    ov_nxt     = ov_r && !out_tready;
    o_blk_nxt  = o_blk_r;
    o_node_nxt = o_node_r;
    o_none_nxt = o_none_r;
    o_last_nxt = o_last_r;
    job_pop    = 1'b0;
    done.valid = 1'b0;
    done.bank  = bank_r;
    rd_en      = 1'b0;
    rd_addr    = {bank_r, idx_r};
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop  = 1'b1;
          bank_nxt = job.bank;
          kept_nxt = job.kept;
          n_nxt    = REP_N_W'((want_c < kept_c) ? want_c : kept_c);
          rem_nxt  = '0;
          step_nxt = MOD_STEP_W'(NODE_IDX_W - 1);
          state_nxt = (job.kept == '0) ? BK_NONE : BK_MOD;
        end
      end
      BK_MOD: begin
        rem_nxt  = rem_step[NODE_IDX_W-1:0];
        step_nxt = step_r - MOD_STEP_W'(1);
        if (step_r == '0) begin
          idx_nxt   = rem_step[NODE_IDX_W-1:0];
          i_nxt     = '0;
          rd_en     = 1'b1;
          rd_addr   = {bank_r, rem_step[NODE_IDX_W-1:0]};
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_blk_nxt  = blk_r;
          o_node_nxt = rd_data_r;
          o_none_nxt = 1'b0;
          o_last_nxt = is_last_pick;
          idx_nxt    = idx_inc;
          if (is_last_pick) begin
            ptr_nxt    = idx_inc;
            blk_nxt    = blk_r + BLOCK_ID_W'(1);
            done.valid = 1'b1;
            state_nxt  = BK_IDLE;
          end else begin
            i_nxt   = i_r + REP_N_W'(1);
            rd_en   = 1'b1;
            rd_addr = {bank_r, idx_inc};
          end
        end
      end
      BK_NONE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_blk_nxt  = '0;
          o_node_nxt = '0;
          o_none_nxt = 1'b1;
          o_last_nxt = 1'b1;
          done.valid = 1'b1;
          state_nxt  = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ptr_r   <= '0;
      blk_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      blk_r   <= blk_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    bank_r   <= bank_nxt;
    kept_r   <= kept_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    o_blk_r  <= o_blk_nxt;
    o_node_r <= o_node_nxt;
    o_none_r <= o_none_nxt;
    o_last_r <= o_last_nxt;
  end

  // id store write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {o_node_r, o_blk_r};
  assign out_tuser  = o_none_r;
  assign out_tlast  = o_last_r;

  a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MOD) |-> (kept_r != '0))
    else $error("remainder started with an empty list");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |=> (state_r == BK_IDLE))
    else $error("bank released while placement still running");

endmodule

`default_nettype wire

### hw/rtl/round_robin_replica_placement.sv
// top level: configuration registers, front, job queue and back
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tdata: node_id, node_alive, free space; tlast: last_node
// out_     out  out_tvalid/out_tready  tdata: block id, chosen_node; tuser: no_node; tlast: last
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data; always ready
//
// node entries are taken one per cycle; the list fills one of two id banks
// after a last entry the back pops the job, reduces the pointer modulo the kept
// count one remainder bit per step, then gives one result per cycle unless the receiver stalls
// the front fills the other bank meanwhile and stalls only when both banks wait
// reset is synchronous; the id store needs no clearing, only filled entries are read
`timescale 1ns / 1ps
`default_nettype none

module round_robin_replica_placement (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // node_id[15:0], node_alive[16], free space[64:17], zero fill[71:65]
  input  wire logic [rrrp_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // block id[47:0], chosen_node[63:48]
  output logic [rrrp_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // no_node[0]
  output logic                                     out_tuser,
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rrrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rrrp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rrrp_pkg::*;

  logic [BSIZE_W-1:0] block_size_r, block_size_nxt;
  logic [REPL_W-1:0]  replication_r, replication_nxt;

  mem_wr_t    wr;
  job_t       push_job;
  job_t       job;
  logic       job_push;
  logic       job_pop;
  logic       job_valid;
  bank_done_t done;

  assign cfg_ready = 1'b1;

  // configuration register decode
  always_comb begin
    block_size_nxt  = block_size_r;
    replication_nxt = replication_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:  block_size_nxt  = cfg_data[BSIZE_W-1:0];
        CFG_REPLICATION: replication_nxt = cfg_data[REPL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= BLOCK_SIZE_RST;
      replication_r <= REPLICATION_RST;
    end else begin
      block_size_r  <= block_size_nxt;
      replication_r <= replication_nxt;
    end
  end

  rrrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .block_size (block_size_r),
    .done       (done),
    .wr         (wr),
    .job_push   (job_push),
    .job        (push_job)
  );

  rrrp_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .pop       (job_pop),
    .job_valid (job_valid),
    .job       (job)
  );

  rrrp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .job_valid   (job_valid),
    .job         (job),
    .job_pop     (job_pop),
    .replication (replication_r),
    .done        (done),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

### dv/round_robin_replica_placement_tb.sv
// testbench for the round robin replica placement block: directed table, random lists, checker
`timescale 1ns / 1ps

module round_robin_replica_placement_tb;
  import rrrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 32;
  localparam int OVERFLOW_LEN   = MAX_NODES + 2;
  localparam int DIR_N          = 22;
  localparam logic [SPACE_W-1:0] SPACE_MAX = '1;

  // one placement result as seen on the result stream
  typedef struct packed {
    logic [BLOCK_ID_W-1:0] blk_id;
    logic [NODE_ID_W-1:0]  chosen_node;
    logic                  no_node;
    logic                  last;
  } replica_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct packed {
    logic [NODE_ID_W-1:0] node_id;
    logic                 alive;
    logic [SPACE_W-1:0]   space;
    logic                 last_node;
    logic                 typed;
    replica_t             typed_res;
  } node_row_t;

  localparam replica_t NO_NODE_RES = '{48'd0, 16'd0, 1'b1, 1'b1};
  localparam replica_t FROM_MODEL  = '{48'd0, 16'd0, 1'b0, 1'b0};

  // reset config: block size 64 MiB, three replicas
  localparam node_row_t DIR_ROWS [DIR_N] = '{
    // dead node alone, then a node one byte short: no eligible node
    '{16'h1234, 1'b0, SPACE_MAX,          1'b1, 1'b1, NO_NODE_RES},
    '{16'hFFFF, 1'b1, 48'h0000_03FF_FFFF, 1'b1, 1'b1, NO_NODE_RES},
    // free space exactly the block size, single node list
    '{16'h0000, 1'b1, 48'h0000_0400_0000, 1'b1, 1'b1, '{48'd0, 16'h0000, 1'b0, 1'b1}},
    // mixed list: dead and short nodes are skipped
    '{16'hFFFF, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'hAAAA, 1'b1, 48'h8000_0000_0000, 1'b0, 1'b0, FROM_MODEL},
    '{16'h5555, 1'b0, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0001, 1'b1, 48'h0000_0000_0000, 1'b0, 1'b0, FROM_MODEL},
    '{16'h1357, 1'b1, 48'h0000_0400_0000, 1'b0, 1'b0, FROM_MODEL},
    '{16'h2468, 1'b1, 48'h0000_FFFF_FFFF, 1'b1, 1'b0, FROM_MODEL},
    // short lists, pointer reduced modulo kept count
    '{16'h00FF, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'hFF00, 1'b1, SPACE_MAX,          1'b1, 1'b0, FROM_MODEL},
    '{16'h8000, 1'b1, SPACE_MAX,          1'b1, 1'b0, FROM_MODEL},
    '{16'h0101, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0202, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0303, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0404, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0505, 1'b1, SPACE_MAX,          1'b1, 1'b0, FROM_MODEL},
    // selection wraps past the end of the kept list
    '{16'h0606, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0707, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0808, 1'b1, SPACE_MAX,          1'b0, 1'b0, FROM_MODEL},
    '{16'h0909, 1'b1, SPACE_MAX,          1'b1, 1'b0, FROM_MODEL},
    // empty list leaves pointer and block id alone
    '{16'h7777, 1'b0, 48'h0000_0000_0000, 1'b1, 1'b1, NO_NODE_RES}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // placement predictor state
  logic [NODE_ID_W-1:0]  kept_ids [MAX_NODES];
  int unsigned           kept_cnt;
  int unsigned           rr_ptr;
  logic [BLOCK_ID_W-1:0] next_blk;
  logic [BSIZE_W-1:0]    blk_size;
  logic [REPL_W-1:0]     repl;
  replica_t              placed [MAX_REPLICAS];

  replica_t replica_q [$];
  int       mismatches;
  int       idle_cycles;
  logic     tx_burst;
  logic     hold_req;

  round_robin_replica_placement dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor: absorb one node entry, fill placed[] and return the result count
  function automatic int place_entry(input logic [NODE_ID_W-1:0] id, input logic alive,
                                     input logic [SPACE_W-1:0] space, input logic last_node);
    int unsigned kept, want, n, start;
    if (alive && space >= {16'd0, blk_size} && kept_cnt < MAX_NODES) begin
      kept_ids[kept_cnt] = id;
      kept_cnt++;
    end
    if (!last_node) return 0;
    kept     = kept_cnt;
    kept_cnt = 0;
    if (kept == 0) begin
      placed[0] = NO_NODE_RES;
      return 1;
    end
    want = (repl == 0) ? 1 : ((repl > MAX_REPLICAS) ? MAX_REPLICAS : repl);
    n     = (want < kept) ? want : kept;
    start = rr_ptr % kept;
    for (int i = 0; i < n; i++) begin
      placed[i].blk_id      = next_blk;
      placed[i].chosen_node = kept_ids[(start + i) % kept];
      placed[i].no_node     = 1'b0;
      placed[i].last        = (i + 1 == n);
    end
    rr_ptr   = (start + n) % kept;
    next_blk = next_blk + 1'b1;
    return n;
  endfunction

  // drive one node entry from a falling edge, return at the falling edge after the transfer
  task automatic send_node(input logic [NODE_ID_W-1:0] id, input logic alive,
                           input logic [SPACE_W-1:0] space, input logic last_node,
                           input logic typed, input replica_t typed_res);
    int gap, n;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'd0, space, alive, id};
    in_tlast  = last_node;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = place_entry(id, alive, space, last_node);
    if (typed) begin
      replica_q.insert(replica_q.size(), typed_res);
    end else begin
      for (int i = 0; i < n; i++) replica_q.insert(replica_q.size(), placed[i]);
    end
    @(negedge clk);
  endtask

  // free space mix around the current threshold and at the extremes
  function automatic logic [SPACE_W-1:0] rand_space();
    logic [SPACE_W-1:0] r;
    r = SPACE_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SPACE_MAX;
      2: return {16'd0, blk_size};
      3: return {16'd0, blk_size} - 1'b1;
      4: return {16'd0, 32'($urandom())};
      default: return r;
    endcase
  endfunction

  // one node list; a dead list ends in a no node result
  task automatic send_list(input int len, input logic dead, input logic all_alive);
    logic alive;
    for (int i = 0; i < len; i++) begin
      alive = all_alive || (!dead && $urandom_range(0, 7) != 0);
      send_node(16'($urandom()), alive, rand_space(), i == len - 1, 1'b0, FROM_MODEL);
    end
  endtask

  // random lists until about the given number of entries went out
  task automatic run_lists(input int items, input logic burst);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len      = $urandom_range(1, 8);
      tx_burst = burst || ($urandom_range(0, 3) == 0);
      send_list(len, $urandom_range(0, 7) == 0, 1'b0);
      sent += len;
    end
    tx_burst = 1'b0;
  endtask

  // register write from a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_BLOCK_SIZE) blk_size = data;
    else repl = data[REPL_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until every placement came back and the back end went quiet
  task automatic settle();
    in_tvalid = 1'b0;
    while (replica_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result(input logic [OUT_TDATA_W-1:0] data, input logic user,
                              input logic last_flag);
    replica_t got, want;
    got.blk_id      = data[47:0];
    got.chosen_node = data[63:48];
    got.no_node     = user;
    got.last        = last_flag;
    if (replica_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: block %h node %h none %b last %b",
                 $realtime, got.blk_id, got.chosen_node, got.no_node, got.last);
      return;
    end
    want = replica_q.pop_front();
    if (got.blk_id !== want.blk_id || got.chosen_node !== want.chosen_node ||
        got.no_node !== want.no_node || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp block %h node %h none %b last %b, got %h %h %b %b",
                 $realtime, want.blk_id, want.chosen_node, want.no_node, want.last,
                 got.blk_id, got.chosen_node, got.no_node, got.last);
    end
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int gap, quiet;
    quiet      = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (quiet > 0) begin
        gap = 0;
        quiet--;
      end else begin
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) quiet = 20;
      end
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      check_result(out_tdata, out_tuser, out_tlast);
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_BLOCK_SIZE;
    cfg_data    = '0;
    tx_burst    = 1'b0;
    hold_req    = 1'b0;
    mismatches  = 0;
    kept_cnt    = 0;
    rr_ptr      = 0;
    next_blk    = '0;
    blk_size    = BLOCK_SIZE_RST;
    repl        = REPLICATION_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table under reset config
    for (int r = 0; r < DIR_N; r++)
      send_node(DIR_ROWS[r].node_id, DIR_ROWS[r].alive, DIR_ROWS[r].space,
                DIR_ROWS[r].last_node, DIR_ROWS[r].typed, DIR_ROWS[r].typed_res);
    settle();

    // any alive node qualifies, zero replication acts as one
    write_reg(CFG_BLOCK_SIZE, 32'd0);
    write_reg(CFG_REPLICATION, 32'd0);
    run_lists(6, 1'b0);
    settle();

    // highest threshold, replication saturates at the maximum
    write_reg(CFG_BLOCK_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_REPLICATION, 32'd15);
    run_lists(6, 1'b0);
    settle();

    // random threshold, single replica
    write_reg(CFG_BLOCK_SIZE, $urandom());
    write_reg(CFG_REPLICATION, 32'd1);
    run_lists(6, 1'b0);
    settle();

    // receiver holds off while lists keep coming, then one list past capacity
    write_reg(CFG_BLOCK_SIZE, 32'd0);
    write_reg(CFG_REPLICATION, 32'd8);
    hold_req = 1'b1;
    run_lists(12, 1'b1);
    send_list(OVERFLOW_LEN, 1'b0, 1'b1);
    settle();

    // random replication count to finish
    write_reg(CFG_REPLICATION, $urandom_range(0, 15));
    run_lists(6, 1'b0);
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
